@@ rtl/ultrasonic_ping_median_unit_defines.svh @@
// Assertion macros shared by the ranging unit.
// Included by the top level; needs a clk and an active-low rst_n in scope.
`ifndef ULTRASONIC_PING_MEDIAN_UNIT_DEFINES_SVH
`define ULTRASONIC_PING_MEDIAN_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/upm_pkg.sv @@
// Shared types and constants of the ultrasonic ranging unit.
// Used by every module of the block; depends on nothing.
package upm_pkg;

  // Field and counter widths fixed by the interface.
  localparam int TICK_W     = 17;
  localparam int DUR_W      = 16;
  localparam int PD_W       = 5;
  localparam int GOOD_W     = 5;
  localparam int PC_W       = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PH_W       = 3;

  // Ping phases.
  localparam logic [PH_W-1:0] PH_IDLE      = 3'd0;
  localparam logic [PH_W-1:0] PH_TRIG_LOW  = 3'd1;
  localparam logic [PH_W-1:0] PH_TRIG_HIGH = 3'd2;
  localparam logic [PH_W-1:0] PH_WAIT_RISE = 3'd3;
  localparam logic [PH_W-1:0] PH_ECHO_HIGH = 3'd4;
  localparam logic [PH_W-1:0] PH_GAP       = 3'd5;

  // Trigger pulse shape in ticks.
  localparam logic [TICK_W-1:0] TRIG_LOW_TICKS  = 17'd4;
  localparam logic [TICK_W-1:0] TRIG_HIGH_TICKS = 17'd10;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PING_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PING_GAP     = 2'd2;

  localparam logic [15:0]     ECHO_TIMEOUT_RST = 16'd46500;
  localparam logic [PC_W-1:0] PING_COUNT_RST   = 5'd5;
  localparam logic [15:0]     PING_GAP_RST     = 16'd1000;

  // One tick request after classification.
  typedef struct packed {
    logic start;
    logic echo;
  } upm_item_t;

  // Command pulses from the controller to the sorted store.
  typedef struct packed {
    logic             clear;
    logic             ins;
    logic             med;
    logic [DUR_W-1:0] value;
  } upm_st_req_t;

  // Result packed with the last field in the lowest bits.
  typedef struct packed {
    logic [GOOD_W-1:0] good_pings;
    logic [DUR_W-1:0]  median_us;
    logic              no_echo;
    logic              done_res;
    logic              busy_res;
    logic              trigger_level;
  } upm_result_t;

endpackage

@@ rtl/upm_front.sv @@
// Front end: accepts tick requests, classifies them and queues them.
// Depends on upm_pkg for the item type.
module upm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic              in_echo,
  output logic              q_valid,
  input  logic              q_ready,
  output upm_pkg::upm_item_t q_item
);

  upm_pkg::upm_item_t slot_r [2];
  logic               wr_ptr_r, wr_ptr_nxt;
  logic               rd_ptr_r, rd_ptr_nxt;
  logic [1:0]         fill_r, fill_nxt;
  logic               push, pop;
  upm_pkg::upm_item_t cls_item;

  // Classify the incoming request: start request or plain tick.
  always_comb begin
    cls_item.start = in_action;
    cls_item.echo  = in_echo;
  end

  assign in_ready = (fill_r != 2'd2);
  assign q_valid  = (fill_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Queue pointers and fill level.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

@@ rtl/upm_store.sv @@
// Sorted store of good echo durations with insertion and median readout.
// Depends on upm_pkg; one write port and one registered read port.
module upm_store #(
  parameter int MAX_PINGS = 16,
  parameter int CNT_W     = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  upm_pkg::upm_st_req_t    req,
  output logic                    ack,
  output logic [upm_pkg::DUR_W-1:0] median,
  output logic [CNT_W-1:0]        total
);

  localparam int IDX_W = (MAX_PINGS > 1) ? $clog2(MAX_PINGS) : 1;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_INS_RD  = 3'd1;
  localparam logic [2:0] ST_INS_CMP = 3'd2;
  localparam logic [2:0] ST_MED_W0  = 3'd3;
  localparam logic [2:0] ST_MED_W1  = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [CNT_W-1:0]            total_r, total_nxt;
  logic [CNT_W-1:0]            idx_r, idx_nxt;
  logic [CNT_W-1:0]            idx_dec;
  logic [CNT_W-1:0]            half;
  logic [upm_pkg::DUR_W-1:0]   val_r, val_nxt;
  logic [upm_pkg::DUR_W-1:0]   first_r, first_nxt;
  logic [upm_pkg::DUR_W-1:0]   median_r, median_nxt;
  logic [upm_pkg::DUR_W:0]     pair_sum;
  logic [upm_pkg::DUR_W-1:0]   sorted_mem_r [MAX_PINGS];
  logic [upm_pkg::DUR_W-1:0]   rd_data_r;
  logic [IDX_W-1:0]            mem_ra, mem_wa;
  logic [upm_pkg::DUR_W-1:0]   mem_wd;
  logic                        mem_we;

  assign total    = total_r;
  assign median   = median_r;
  assign idx_dec  = idx_r - CNT_W'(1);
  assign half     = total_r >> 1;
  assign pair_sum = {1'b0, first_r} + {1'b0, rd_data_r};

  // Sequencer: insertion by read-compare shifts; median in up to two reads.
  always_comb begin
    state_nxt  = state_r;
    total_nxt  = total_r;
    idx_nxt    = idx_r;
    val_nxt    = val_r;
    first_nxt  = first_r;
    median_nxt = median_r;
    ack        = 1'b0;
    mem_ra     = idx_dec[IDX_W-1:0];
    mem_wa     = idx_r[IDX_W-1:0];
    mem_wd     = val_r;
    mem_we     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (req.clear) begin
          total_nxt = '0;
        end else if (req.ins) begin
          if (total_r >= CNT_W'(MAX_PINGS)) begin
            ack = 1'b1;
          end else begin
            idx_nxt   = total_r;
            val_nxt   = req.value;
            state_nxt = ST_INS_RD;
          end
        end else if (req.med) begin
          if (total_r == '0) begin
            median_nxt = '0;
            ack        = 1'b1;
          end else begin
            idx_nxt   = half;
            mem_ra    = half[IDX_W-1:0];
            state_nxt = ST_MED_W0;
          end
        end
      end
      ST_INS_RD: begin
        if (idx_r == '0) begin
          mem_we    = 1'b1;
          total_nxt = total_r + CNT_W'(1);
          ack       = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        mem_we = 1'b1;
        if (rd_data_r > val_r) begin
          mem_wd    = rd_data_r;
          idx_nxt   = idx_dec;
          state_nxt = ST_INS_RD;
        end else begin
          total_nxt = total_r + CNT_W'(1);
          ack       = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_MED_W0: begin
        first_nxt = rd_data_r;
        if (total_r[0]) begin
          median_nxt = rd_data_r;
          ack        = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_MED_W1;
        end
      end
      ST_MED_W1: begin
        median_nxt = pair_sum[upm_pkg::DUR_W:1];
        ack        = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    val_r    <= val_nxt;
    first_r  <= first_nxt;
    median_r <= median_nxt;
  end

  // Sample memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sorted_mem_r[mem_wa] <= mem_wd;
    end
    rd_data_r <= sorted_mem_r[mem_ra];
  end

endmodule

@@ rtl/upm_ctrl.sv @@
// Back end: ping phase machine per tick, store commands and result register.
// Depends on upm_pkg; drives upm_store through a command struct.
module upm_ctrl #(
  parameter int MAX_PINGS = 16,
  parameter int CNT_W     = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  upm_pkg::upm_item_t            q_item,
  input  logic [15:0]                   echo_timeout,
  input  logic [upm_pkg::PC_W-1:0]      ping_count,
  input  logic [15:0]                   ping_gap,
  output upm_pkg::upm_st_req_t          st_req,
  input  logic                          st_ack,
  input  logic [upm_pkg::DUR_W-1:0]     st_median,
  input  logic [CNT_W-1:0]              st_total,
  output logic                          out_valid,
  input  logic                          out_ready,
  output upm_pkg::upm_result_t          out_result
);

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_INS  = 2'd1;
  localparam logic [1:0] BK_MED  = 2'd2;
  localparam logic [1:0] BK_OUT  = 2'd3;

  localparam logic [6:0] MAX_P = 7'(MAX_PINGS);

  logic [1:0]                    bk_r, bk_nxt;
  logic [upm_pkg::PH_W-1:0]      phase_r, phase_nxt;
  logic [upm_pkg::TICK_W-1:0]    tick_r, tick_nxt;
  logic [upm_pkg::PD_W-1:0]      pd_r, pd_nxt;
  logic                          trig_r, trig_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  upm_pkg::upm_st_req_t          req_r, req_nxt;
  logic                          out_valid_r, out_valid_nxt;
  upm_pkg::upm_result_t          out_r, out_nxt;

  logic                          pop;
  logic                          start_eff;
  logic [upm_pkg::PH_W-1:0]      ph, ph_n;
  logic [upm_pkg::TICK_W-1:0]    tc, tc_n, tc_inc;
  logic [upm_pkg::PD_W-1:0]      pd, pd_n;
  logic                          trig, ping_end, ping_good, gap_end, done_now;
  logic [6:0]                    eff_count;
  logic [6:0]                    pc_ext;

  assign q_ready    = (bk_r == BK_IDLE);
  assign pop        = q_valid && q_ready;
  assign st_req     = req_r;
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  // Pings per measurement, held between one and the store depth.
  always_comb begin
    pc_ext = {2'b00, ping_count};
    if (pc_ext == 7'd0) begin
      eff_count = 7'd1;
    end else if (pc_ext > MAX_P) begin
      eff_count = MAX_P;
    end else begin
      eff_count = pc_ext;
    end
  end

  // One tick of the ping phase machine.
  always_comb begin
    start_eff = (phase_r == upm_pkg::PH_IDLE) && q_item.start;
    ph        = start_eff ? upm_pkg::PH_TRIG_LOW : phase_r;
    tc        = start_eff ? '0 : tick_r;
    pd        = start_eff ? '0 : pd_r;
    tc_inc    = tc + upm_pkg::TICK_W'(1);
    ph_n      = ph;
    tc_n      = tc;
    pd_n      = pd;
    trig      = 1'b0;
    ping_end  = 1'b0;
    ping_good = 1'b0;
    gap_end   = 1'b0;
    done_now  = 1'b0;
    unique case (ph)
      upm_pkg::PH_TRIG_LOW: begin
        tc_n = tc_inc;
        if (tc_inc >= upm_pkg::TRIG_LOW_TICKS) begin
          ph_n = upm_pkg::PH_TRIG_HIGH;
          tc_n = '0;
        end
      end
      upm_pkg::PH_TRIG_HIGH: begin
        trig = 1'b1;
        tc_n = tc_inc;
        if (tc_inc >= upm_pkg::TRIG_HIGH_TICKS) begin
          ph_n = upm_pkg::PH_WAIT_RISE;
          tc_n = '0;
        end
      end
      upm_pkg::PH_WAIT_RISE: begin
        if (q_item.echo) begin
          // Echo already high on the first watch tick fails the ping.
          if (tc == '0) begin
            ping_end = 1'b1;
          end else begin
            ph_n = upm_pkg::PH_ECHO_HIGH;
            tc_n = upm_pkg::TICK_W'(1);
          end
        end else begin
          tc_n = tc_inc;
          if (tc_inc > {1'b0, echo_timeout}) begin
            ping_end = 1'b1;
          end
        end
      end
      upm_pkg::PH_ECHO_HIGH: begin
        if (!q_item.echo) begin
          ping_end  = 1'b1;
          ping_good = 1'b1;
        end else begin
          tc_n = tc_inc;
          if (tc_inc > {1'b0, echo_timeout}) begin
            ping_end = 1'b1;
          end
        end
      end
      upm_pkg::PH_GAP: begin
        tc_n = tc_inc;
        if (tc_inc >= {1'b0, ping_gap}) begin
          gap_end = 1'b1;
        end
      end
      default: begin
        ph_n = upm_pkg::PH_IDLE;
      end
    endcase

    if (ping_end) begin
      pd_n = pd + upm_pkg::PD_W'(1);
      tc_n = '0;
      if (ping_gap == 16'd0) begin
        gap_end = 1'b1;
      end else begin
        ph_n = upm_pkg::PH_GAP;
      end
    end

    if (gap_end) begin
      tc_n = '0;
      if ({2'b00, pd_n} >= eff_count) begin
        done_now = 1'b1;
        ph_n     = upm_pkg::PH_IDLE;
      end else begin
        ph_n = upm_pkg::PH_TRIG_LOW;
      end
    end
  end

  // Back-end sequence: tick update, optional insert, optional median, result.
  always_comb begin
    bk_nxt        = bk_r;
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    pd_nxt        = pd_r;
    trig_nxt      = trig_r;
    busy_nxt      = busy_r;
    done_nxt      = done_r;
    req_nxt       = '0;
    req_nxt.value = req_r.value;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    unique case (bk_r)
      BK_IDLE: begin
        if (pop) begin
          phase_nxt     = ph_n;
          tick_nxt      = tc_n;
          pd_nxt        = pd_n;
          trig_nxt      = trig;
          busy_nxt      = (ph_n != upm_pkg::PH_IDLE);
          done_nxt      = done_now;
          req_nxt.clear = start_eff;
          req_nxt.value = tc[upm_pkg::DUR_W-1:0];
          if (ping_good) begin
            req_nxt.ins = 1'b1;
            bk_nxt      = BK_INS;
          end else if (done_now) begin
            req_nxt.med = 1'b1;
            bk_nxt      = BK_MED;
          end else begin
            bk_nxt = BK_OUT;
          end
        end
      end
      BK_INS: begin
        if (st_ack) begin
          if (done_r) begin
            req_nxt.med = 1'b1;
            bk_nxt      = BK_MED;
          end else begin
            bk_nxt = BK_OUT;
          end
        end
      end
      BK_MED: begin
        if (st_ack) begin
          bk_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_nxt.trigger_level = trig_r;
          out_nxt.busy_res      = busy_r;
          out_nxt.done_res      = done_r;
          out_nxt.no_echo       = done_r && (st_total == '0);
          out_nxt.median_us     = (done_r && (st_total != '0)) ? st_median : '0;
          out_nxt.good_pings    = done_r ? upm_pkg::GOOD_W'(st_total) : '0;
          bk_nxt                = BK_IDLE;
        end
      end
      default: begin
        bk_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bk_r        <= BK_IDLE;
      phase_r     <= upm_pkg::PH_IDLE;
      tick_r      <= '0;
      pd_r        <= '0;
      req_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bk_r        <= bk_nxt;
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      pd_r        <= pd_nxt;
      req_r       <= req_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    trig_r <= trig_nxt;
    busy_r <= busy_nxt;
    done_r <= done_nxt;
    out_r  <= out_nxt;
  end

endmodule

@@ rtl/ultrasonic_ping_median_unit.sv @@
// Ultrasonic ranging unit with median filter over a burst of pings. Every input
// request is one microsecond tick (tuser set on a start request) and gives exactly
// one result. A plain tick passes the controller's tick update and result register.
// A tick that ends a good ping also waits for the sorted insertion, which shifts
// each larger stored sample up one place through the sample memory (at most
// MAX_PINGS - 1 shifts) and is skipped when the store is already full. The
// tick that closes a measurement also waits for the median reads (none with no
// samples, one for an odd count, two for an even count). A two-entry request queue
// and an output register let both sides stall.
// The user must write configuration registers through the cfg channel only while idle; the block does not enforce it.
module ultrasonic_ping_median_unit #(
  parameter int MAX_PINGS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] echo_level, [7:1] zero
  input  logic [0:0]  in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] trigger_level, [1] busy_res, [2] done_res, [3] no_echo,
  // [19:4] median_us, [24:20] good_pings, [31:25] zero
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [upm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [upm_pkg::CFG_DATA_W-1:0] cfg_data
);

  `include "ultrasonic_ping_median_unit_defines.svh"

  localparam int CNT_W = $clog2(MAX_PINGS + 1);

  logic [15:0]                 echo_timeout_r;
  logic [upm_pkg::PC_W-1:0]    ping_count_r;
  logic [15:0]                 ping_gap_r;

  logic                        q_valid, q_ready;
  upm_pkg::upm_item_t          q_item;
  upm_pkg::upm_st_req_t        st_req;
  logic                        st_ack;
  logic [upm_pkg::DUR_W-1:0]   st_median;
  logic [CNT_W-1:0]            st_total;
  upm_pkg::upm_result_t        out_result;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_timeout_r <= upm_pkg::ECHO_TIMEOUT_RST;
      ping_count_r   <= upm_pkg::PING_COUNT_RST;
      ping_gap_r     <= upm_pkg::PING_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        upm_pkg::REG_ECHO_TIMEOUT: echo_timeout_r <= cfg_data;
        upm_pkg::REG_PING_COUNT:   ping_count_r   <= cfg_data[upm_pkg::PC_W-1:0];
        upm_pkg::REG_PING_GAP:     ping_gap_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  upm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser[0]),
    .in_echo   (in_tdata[0]),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  upm_store #(
    .MAX_PINGS (MAX_PINGS),
    .CNT_W     (CNT_W)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (st_req),
    .ack    (st_ack),
    .median (st_median),
    .total  (st_total)
  );

  upm_ctrl #(
    .MAX_PINGS (MAX_PINGS),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .echo_timeout (echo_timeout_r),
    .ping_count   (ping_count_r),
    .ping_gap     (ping_gap_r),
    .st_req       (st_req),
    .st_ack       (st_ack),
    .st_median    (st_median),
    .st_total     (st_total),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_result   (out_result)
  );

  assign out_tdata = {7'b0000000, out_result};

  // A done result never reports the measurement as still running.
  `UPM_ASSERT_NOW(a_done_not_busy, out_tvalid && out_result.done_res,
                  !out_result.busy_res, "done result with busy set")

  // A failed measurement carries no median and no good pings.
  `UPM_ASSERT_NOW(a_no_echo_clean, out_tvalid && out_result.no_echo,
                  out_result.done_res && (out_result.median_us == '0) &&
                  (out_result.good_pings == '0), "no_echo result with stale fields")

  // The sample count never runs past the store depth.
  `UPM_ASSERT_NOW(a_total_bound, 1'b1, st_total <= CNT_W'(MAX_PINGS),
                  "sample count beyond store depth")

  // An insert command is never followed straight away by another insert or a clear.
  `UPM_ASSERT_NEXT(a_ins_after_pop, st_req.ins, !st_req.clear && !st_req.ins,
                   "insert command repeated or mixed with clear")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the ultrasonic ranging unit with median filter.
// Drives tick requests and register writes, predicts every result in place, and
// checks each one as it leaves the block. Depends on upm_pkg and the RTL top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_SLOTS = 16;
  localparam int STALL_LIMIT  = 4000;
  localparam int NEVER        = 1 << 24;
  localparam int RANDOM_TICKS = 400;
  localparam int CALM_TICKS   = 120;
  localparam int MAX_REPORTS  = 20;

  // How the echo of one ping is shaped.
  typedef enum int {
    PING_LIMIT, PING_EARLY, PING_RISE_LATE, PING_STUCK_HIGH, PING_GOOD
  } ping_kind_t;

  // How pings are chosen across a measurement.
  typedef enum int {MIX_RANDOM, MIX_CYCLE, MIX_DEAD} ping_mix_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;   // [0] echo_level, [7:1] zero
  logic [0:0]  in_tuser = 1'b0;   // [0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [0] trigger_level, [1] busy_res, [2] done_res, [3] no_echo,
  // [19:4] median_us, [24:20] good_pings, [31:25] zero
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [upm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [upm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted block state and register copies.
  logic [upm_pkg::PH_W-1:0]   ph_q = upm_pkg::PH_IDLE;
  logic [upm_pkg::TICK_W-1:0] tc_q = '0;
  logic [upm_pkg::PD_W-1:0]   pd_q = '0;
  logic [upm_pkg::GOOD_W-1:0] st_q = '0;
  logic [upm_pkg::DUR_W-1:0]  srt_q [SAMPLE_SLOTS];
  logic [15:0]                tmo_q = upm_pkg::ECHO_TIMEOUT_RST;
  logic [upm_pkg::PC_W-1:0]   pc_q = upm_pkg::PING_COUNT_RST;
  logic [15:0]                gap_q = upm_pkg::PING_GAP_RST;
  bit                         done_q;

  upm_pkg::upm_result_t pending_results[$];
  int          ticks_sent;
  int          results_seen;
  int          fail_count;
  int          stuck_cycles;
  int          stall_left;
  bit          idle_on;

  ultrasonic_ping_median_unit #(.MAX_PINGS(SAMPLE_SLOTS)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Finish the measurement or start the next ping.
  function automatic void gap_end();
    logic [upm_pkg::PC_W-1:0] pings;
    pings = (pc_q == 0) ? 5'd1 : ((pc_q > SAMPLE_SLOTS) ? 5'(SAMPLE_SLOTS) : pc_q);
    if (pd_q >= pings) begin
      done_q = 1'b1;
      ph_q = upm_pkg::PH_IDLE;
    end else begin
      ph_q = upm_pkg::PH_TRIG_LOW;
    end
    tc_q = '0;
  endfunction

  // Close one ping; a good duration goes into the sorted store.
  function automatic void close_ping(input bit good,
                                     input logic [upm_pkg::TICK_W-1:0] dur);
    int i;
    if (good && st_q < SAMPLE_SLOTS) begin
      i = st_q;
      while (i > 0 && {1'b0, srt_q[i-1]} > dur) begin
        srt_q[i] = srt_q[i-1];
        i--;
      end
      srt_q[i] = dur[upm_pkg::DUR_W-1:0];
      st_q = st_q + 1'b1;
    end
    pd_q = pd_q + 1'b1;
    tc_q = '0;
    if (gap_q == 0) gap_end();
    else ph_q = upm_pkg::PH_GAP;
  endfunction

  // Advance the predicted state by one tick and return the expected result.
  function automatic upm_pkg::upm_result_t predict_tick(input logic act, input logic echo);
    upm_pkg::upm_result_t r;
    logic [upm_pkg::DUR_W:0] pair_sum;
    int h;
    r = '0;
    done_q = 1'b0;
    if (ph_q == upm_pkg::PH_IDLE && act) begin
      pd_q = '0;
      st_q = '0;
      tc_q = '0;
      ph_q = upm_pkg::PH_TRIG_LOW;
    end
    case (ph_q)
      upm_pkg::PH_TRIG_LOW: begin
        tc_q = tc_q + 1'b1;
        if (tc_q >= upm_pkg::TRIG_LOW_TICKS) begin
          ph_q = upm_pkg::PH_TRIG_HIGH;
          tc_q = '0;
        end
      end
      upm_pkg::PH_TRIG_HIGH: begin
        r.trigger_level = 1'b1;
        tc_q = tc_q + 1'b1;
        if (tc_q >= upm_pkg::TRIG_HIGH_TICKS) begin
          ph_q = upm_pkg::PH_WAIT_RISE;
          tc_q = '0;
        end
      end
      upm_pkg::PH_WAIT_RISE: begin
        if (echo) begin
          if (tc_q == 0) begin
            close_ping(1'b0, '0);
          end else begin
            ph_q = upm_pkg::PH_ECHO_HIGH;
            tc_q = 17'd1;
          end
        end else begin
          tc_q = tc_q + 1'b1;
          if (tc_q > {1'b0, tmo_q}) close_ping(1'b0, '0);
        end
      end
      upm_pkg::PH_ECHO_HIGH: begin
        if (!echo) begin
          close_ping(1'b1, tc_q);
        end else begin
          tc_q = tc_q + 1'b1;
          if (tc_q > {1'b0, tmo_q}) close_ping(1'b0, '0);
        end
      end
      upm_pkg::PH_GAP: begin
        tc_q = tc_q + 1'b1;
        if (tc_q >= {1'b0, gap_q}) gap_end();
      end
      default: ph_q = upm_pkg::PH_IDLE;
    endcase
    r.busy_res = (ph_q != upm_pkg::PH_IDLE);
    r.done_res = done_q;
    if (done_q) begin
      r.good_pings = st_q;
      if (st_q == 0) begin
        r.no_echo = 1'b1;
      end else begin
        h = st_q >> 1;
        if (st_q[0]) begin
          r.median_us = srt_q[h];
        end else begin
          pair_sum = {1'b0, srt_q[h]} + {1'b0, srt_q[h-1]};
          r.median_us = pair_sum[upm_pkg::DUR_W:1];
        end
      end
    end
    return r;
  endfunction

  // Send one tick request; the valid stays up so back-to-back requests need one write.
  task automatic send_tick(input logic act, input logic echo);
    int n;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, echo};
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_tick(act, echo));
    ticks_sent++;
  endtask

  // Stop sending and wait until every predicted result has been checked.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [upm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      upm_pkg::REG_ECHO_TIMEOUT: tmo_q = val;
      upm_pkg::REG_PING_COUNT:   pc_q = val[upm_pkg::PC_W-1:0];
      upm_pkg::REG_PING_GAP:     gap_q = val;
      default: ;
    endcase
  endtask

  // Write all registers once the block has gone quiet.
  task automatic apply_settings(input logic [15:0] tmo, input logic [15:0] cnt,
                                input logic [15:0] gap);
    drain();
    write_reg(upm_pkg::REG_ECHO_TIMEOUT, tmo);
    write_reg(upm_pkg::REG_PING_COUNT, cnt);
    write_reg(upm_pkg::REG_PING_GAP, gap);
    cfg_valid <= 1'b0;
  endtask

  // Run one measurement from the start request until the predicted state is idle.
  // The echo of every ping follows a plan picked when its watch window opens.
  task automatic measure(input ping_mix_t mix, input int max_dur, input int glitch_pct,
                         input int busy_pct);
    ping_kind_t kind;
    int rise_at, fall_at, w, lim, r;
    bit in_watch, watching;
    logic e, a;
    in_watch = 1'b0;
    w = 0;
    rise_at = 0;
    fall_at = 0;
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    while (ph_q != upm_pkg::PH_IDLE) begin
      watching = (ph_q == upm_pkg::PH_WAIT_RISE || ph_q == upm_pkg::PH_ECHO_HIGH);
      if (watching && !in_watch) begin
        in_watch = 1'b1;
        w = 0;
        r = $urandom_range(0, 99);
        case (mix)
          MIX_CYCLE: kind = ping_kind_t'(pd_q % 5);
          MIX_DEAD:  kind = ping_kind_t'(1 + pd_q % 3);
          default: begin
            if (r < 65) kind = PING_GOOD;
            else if (r < 75) kind = PING_LIMIT;
            else if (r < 85) kind = PING_EARLY;
            else if (r < 93) kind = PING_RISE_LATE;
            else kind = PING_STUCK_HIGH;
          end
        endcase
        // Timeouts are only worth waiting for when the timeout is short.
        if (kind != PING_GOOD && kind != PING_EARLY && tmo_q > 60) kind = PING_GOOD;
        lim = (tmo_q == 0) ? 1 : int'(tmo_q);
        case (kind)
          PING_LIMIT: begin
            rise_at = lim;
            fall_at = 2 * lim;
          end
          PING_EARLY: begin
            rise_at = 0;
            fall_at = $urandom_range(1, 5);
          end
          PING_RISE_LATE: begin
            rise_at = NEVER;
            fall_at = NEVER;
          end
          PING_STUCK_HIGH: begin
            rise_at = 1;
            fall_at = NEVER;
          end
          default: begin
            rise_at = $urandom_range(1, (lim < 8) ? lim : 8);
            fall_at = rise_at + $urandom_range(1, (lim < max_dur) ? lim : max_dur);
          end
        endcase
      end
      if (!watching) in_watch = 1'b0;
      if (watching) begin
        e = (w >= rise_at && w < fall_at);
        if ($urandom_range(0, 99) < glitch_pct) e = ~e;
        w++;
      end else begin
        e = 1'($urandom_range(0, 1));
      end
      a = ($urandom_range(0, 99) < busy_pct);
      send_tick(a, e);
    end
  endtask

  // Plain ticks with no measurement, then one measurement at the reset timeout and
  // ping count; the gap is shortened so the burst stays brief.
  task automatic test_reset_settings();
    idle_on = 1'b1;
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    idle_on = 1'b0;
    drain();
    write_reg(upm_pkg::REG_PING_GAP, 16'd0);
    cfg_valid <= 1'b0;
    measure(MIX_RANDOM, 10, 0, 0);
  endtask

  // Every way a ping can fail, at the exact timeout boundaries.
  task automatic test_ping_faults();
    idle_on = 1'b1;
    apply_settings(16'd3, 16'd5, 16'd0);
    measure(MIX_CYCLE, 3, 0, 0);
    apply_settings(16'd1, 16'd5, 16'd1);
    measure(MIX_CYCLE, 1, 0, 0);
    apply_settings(16'd6, 16'd3, 16'd3);
    measure(MIX_DEAD, 6, 0, 0);
    apply_settings(16'd0, 16'd2, 16'd2);
    measure(MIX_RANDOM, 4, 0, 0);
  endtask

  // Ping count at and beyond its limits, with odd and even sample counts.
  task automatic test_count_range();
    idle_on = 1'b1;
    apply_settings(16'd20, 16'd0, 16'd2);
    measure(MIX_RANDOM, 20, 0, 0);
    apply_settings(16'd20, 16'd2, 16'd0);
    measure(MIX_RANDOM, 20, 0, 0);
    apply_settings(16'd25, 16'd31, 16'd0);
    measure(MIX_RANDOM, 3, 0, 0);
    apply_settings(16'd12, 16'd4, 16'd1);
    measure(MIX_RANDOM, 12, 0, 0);
  endtask

  // Largest timeout with long echoes, then a single ping followed by a long gap.
  task automatic test_long_settings();
    idle_on = 1'b0;
    apply_settings(16'hFFFF, 16'd2, 16'd0);
    measure(MIX_RANDOM, 80, 0, 0);
    apply_settings(16'hFFFF, 16'd1, 16'd150);
    measure(MIX_RANDOM, 30, 0, 0);
  endtask

  // Start requests arriving mid-measurement must act as plain ticks.
  task automatic test_start_while_busy();
    idle_on = 1'b1;
    apply_settings(16'd10, 16'd3, 16'd4);
    measure(MIX_RANDOM, 10, 10, 40);
  endtask

  // Random settings and measurements; the tail runs with no idling at all.
  task automatic test_random();
    int target, r, n;
    logic [15:0] tmo, cnt, gap;
    target = ticks_sent + RANDOM_TICKS;
    while (ticks_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 5) tmo = 16'd0;
      else if (r < 10) tmo = 16'd1;
      else if (r < 15) tmo = 16'hFFFF;
      else if (r < 25) tmo = 16'($urandom_range(61, 2000));
      else tmo = 16'($urandom_range(1, 40));
      r = $urandom_range(0, 99);
      if (r < 5) cnt = 16'd0;
      else if (r < 10) cnt = 16'd16;
      else if (r < 15) cnt = 16'($urandom_range(17, 31));
      else if (r < 20) cnt = {11'($urandom_range(1, 2047)), 5'($urandom_range(1, 4))};
      else cnt = 16'($urandom_range(1, 4));
      r = $urandom_range(0, 99);
      if (r < 25) gap = 16'd0;
      else if (r < 35) gap = 16'($urandom_range(6, 40));
      else gap = 16'($urandom_range(1, 5));
      apply_settings(tmo, cnt, gap);
      idle_on = (ticks_sent < target - CALM_TICKS) ? 1'($urandom_range(0, 3) != 0) : 1'b0;
      // A few ticks while idle; the block must simply report them.
      n = $urandom_range(0, 3);
      repeat (n) send_tick(1'b0, 1'($urandom_range(0, 1)));
      r = $urandom_range(0, 99);
      measure((r < 80) ? MIX_RANDOM : ((r < 90) ? MIX_CYCLE : MIX_DEAD),
              $urandom_range(1, 60), ($urandom_range(0, 3) == 0) ? 5 : 0,
              ($urandom_range(0, 3) == 0) ? 10 : 0);
    end
  endtask

  // Receiver with random stall bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each result with the oldest prediction.
  always @(posedge clk) begin
    upm_pkg::upm_result_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got = upm_pkg::upm_result_t'(out_tdata[24:0]);
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t ns: unexpected result, expected none, actual %h", $time, out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got !== want || out_tdata[31:25] !== 7'd0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t ns: result %0d expected trig=%0b busy=%0b done=%0b no_echo=%0b",
                     $time, results_seen, want.trigger_level, want.busy_res,
                     want.done_res, want.no_echo, " median=%0d good=%0d pad=0",
                     want.median_us, want.good_pings);
            $display("%0t ns: result %0d actual   trig=%0b busy=%0b done=%0b no_echo=%0b",
                     $time, results_seen, got.trigger_level, got.busy_res,
                     got.done_res, got.no_echo, " median=%0d good=%0d pad=%0h",
                     got.median_us, got.good_pings, out_tdata[31:25]);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no accepted request on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    idle_on = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_settings();
    test_ping_faults();
    test_count_range();
    test_long_settings();
    test_start_while_busy();
    test_random();
    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
